/* rtl/fwdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-width decimal formatter package
// Shared widths, character codes, register indexes and the double-dabble
// step used by the binary to BCD pipeline.
// ----------------------------------------------------------------------------
package fwdf_pkg;

    // Field widths
    localparam int NUMBER_W = 32;
    localparam int CHAR_W   = 8;
    localparam int CFG_W    = 4;
    localparam int CNT_W    = 4;

    // A 32-bit value has at most ten decimal digits
    localparam int BCD_DIGITS = 10;

    // Binary to BCD pipeline: input bits consumed per register stage
    localparam int BITS_PER_STAGE = 4;
    localparam int NUM_STAGES     = NUMBER_W / BITS_PER_STAGE;

    // Default for the digit saturation limit
    localparam int MAX_DIGITS_DEFAULT = 12;

    // Character codes
    localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'd46;
    localparam logic [CHAR_W-1:0] ZERO_CHAR = 8'd48;

    // Highest dot position that places a point
    localparam logic [CFG_W-1:0] DOT_LIMIT = 4'd10;

    // Configuration register indexes
    localparam logic REG_DIGIT_COUNT  = 1'b0;
    localparam logic REG_DOT_POSITION = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] DIGIT_COUNT_RESET  = 4'd3;
    localparam logic [CFG_W-1:0] DOT_POSITION_RESET = 4'd2;

    typedef logic [3:0] digit_t;
    typedef digit_t [BCD_DIGITS-1:0] bcd_t;

    // One double-dabble iteration: correct every digit of five or more by
    // adding three, then shift the next binary bit in at the bottom.
    function automatic bcd_t dd_step(input bcd_t bcd_in, input logic in_bit);
        bcd_t                     adjusted;
        logic [4*BCD_DIGITS:0]    wide;
        adjusted = bcd_in;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (adjusted[i] >= 4'd5)
            begin
                adjusted[i] = adjusted[i] + 4'd3;
            end
        end
        wide = {adjusted, in_bit};
        return wide[4*BCD_DIGITS-1:0];
    endfunction

endpackage

/* rtl/fixed_width_decimal_formatter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-width decimal formatter
// The first character of a number is presented after its request is taken
// and has passed the 8 binary to BCD stages, the character sequencer and the
// output register. Throughput: one character per cycle while m_tready stays
// high, set by the single character-wide output port; a number gives its
// shown digits plus one character for a point. Numbers enter back to back.
// Reset clears all valid flags and loads digit count 3 and dot position 2.
// ----------------------------------------------------------------------------
module fixed_width_decimal_formatter_unit #(
    parameter int MAX_DIGITS = fwdf_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fwdf_pkg::NUMBER_W-1:0] s_tdata,   // [31:0] number
    // Output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fwdf_pkg::CHAR_W-1:0]   m_tdata,   // [7:0] character
    output logic                          m_tlast,
    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [fwdf_pkg::CFG_W-1:0]    cfg_wdata
);

    localparam int LAST = fwdf_pkg::NUM_STAGES - 1;
    localparam logic [fwdf_pkg::CNT_W-1:0] MAX_SHOWN = fwdf_pkg::CNT_W'(MAX_DIGITS);

    // Configuration registers
    logic [fwdf_pkg::CFG_W-1:0] digit_count_reg;
    logic [fwdf_pkg::CFG_W-1:0] dot_position_reg;

    // Conversion pipeline
    logic [fwdf_pkg::NUM_STAGES-1:0]  valid_reg;
    logic [fwdf_pkg::NUM_STAGES-1:0]  stage_ready;
    fwdf_pkg::bcd_t                   bcd_reg  [fwdf_pkg::NUM_STAGES];
    logic [fwdf_pkg::NUMBER_W-1:0]    bin_reg  [fwdf_pkg::NUM_STAGES];
    fwdf_pkg::bcd_t                   bcd_next [fwdf_pkg::NUM_STAGES];
    logic [fwdf_pkg::NUMBER_W-1:0]    bin_next [fwdf_pkg::NUM_STAGES];
    logic [fwdf_pkg::NUM_STAGES-1:0]  up_valid;

    // Character sequencer
    logic                         ser_valid_reg;
    fwdf_pkg::bcd_t               ser_bcd_reg;
    logic [fwdf_pkg::CNT_W-1:0]   ser_idx_reg;

    // Output register
    logic                         out_valid_reg;
    logic [fwdf_pkg::CHAR_W-1:0]  out_char_reg;
    logic                         out_last_reg;

    // Sequencer decode
    logic [fwdf_pkg::CNT_W-1:0]   shown;
    logic                         dot_on;
    logic [fwdf_pkg::CNT_W-1:0]   char_count;
    logic [fwdf_pkg::CNT_W-1:0]   dot_idx;
    logic                         is_dot;
    logic                         after_dot;
    logic [fwdf_pkg::CNT_W-1:0]   pos;
    logic [fwdf_pkg::CNT_W-1:0]   sel;
    fwdf_pkg::digit_t             digit;
    logic [fwdf_pkg::CHAR_W-1:0]  char_now;
    logic                         last_now;
    logic                         out_load;
    logic                         ser_emit;
    logic                         ser_done;
    logic                         ser_free;
    logic                         ser_take;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg  <= fwdf_pkg::DIGIT_COUNT_RESET;
            dot_position_reg <= fwdf_pkg::DOT_POSITION_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                fwdf_pkg::REG_DIGIT_COUNT:  digit_count_reg  <= cfg_wdata;
                fwdf_pkg::REG_DOT_POSITION: dot_position_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Binary to BCD stages, each taking BITS_PER_STAGE double-dabble steps
    genvar s;
    generate
        for (s = 0; s < fwdf_pkg::NUM_STAGES; s++)
        begin : g_stage
            fwdf_pkg::bcd_t                bcd_in;
            logic [fwdf_pkg::NUMBER_W-1:0] bin_in;

            if (s == 0)
            begin : g_first
                assign bcd_in      = '0;
                assign bin_in      = s_tdata;
                assign up_valid[s] = s_tvalid;
            end
            else
            begin : g_rest
                assign bcd_in      = bcd_reg[s-1];
                assign bin_in      = bin_reg[s-1];
                assign up_valid[s] = valid_reg[s-1];
            end

            if (s == LAST)
            begin : g_tail
                assign stage_ready[s] = !valid_reg[s] || ser_free;
            end
            else
            begin : g_body
                assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];
            end

            always_comb
            begin
                fwdf_pkg::bcd_t                b;
                logic [fwdf_pkg::NUMBER_W-1:0] n;
                b = bcd_in;
                n = bin_in;
                for (int k = 0; k < fwdf_pkg::BITS_PER_STAGE; k++)
                begin
                    b = fwdf_pkg::dd_step(b, n[fwdf_pkg::NUMBER_W-1]);
                    n = {n[fwdf_pkg::NUMBER_W-2:0], 1'b0};
                end
                bcd_next[s] = b;
                bin_next[s] = n;
            end

            // Stage valid flag
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (stage_ready[s])
                begin
                    valid_reg[s] <= up_valid[s];
                end
            end

            // Stage payload
            always_ff @(posedge clk)
            begin
                if (stage_ready[s] && up_valid[s])
                begin
                    bcd_reg[s] <= bcd_next[s];
                    bin_reg[s] <= bin_next[s];
                end
            end
        end
    endgenerate

    assign s_tready = stage_ready[0];

    // Run layout (digit count, point, its place) and the character to emit next
    always_comb
    begin
        shown      = (digit_count_reg > MAX_SHOWN) ? MAX_SHOWN : digit_count_reg;
        dot_on     = (dot_position_reg >= 4'd1) && (dot_position_reg <= fwdf_pkg::DOT_LIMIT);
        char_count = shown + fwdf_pkg::CNT_W'(dot_on);
        dot_idx    = (dot_position_reg > shown) ? '0 : (shown - dot_position_reg);
        is_dot     = dot_on && (ser_idx_reg == dot_idx);
        after_dot  = dot_on && (ser_idx_reg > dot_idx);
        pos        = shown - ser_idx_reg + fwdf_pkg::CNT_W'(after_dot);
        sel        = pos - 4'd1;
        digit      = '0;
        for (int i = 0; i < fwdf_pkg::BCD_DIGITS; i++)
        begin
            if (sel == fwdf_pkg::CNT_W'(i))
            begin
                digit = ser_bcd_reg[i];
            end
        end
        char_now = is_dot ? fwdf_pkg::DOT_CHAR
                          : (fwdf_pkg::ZERO_CHAR + {4'b0000, digit});
        last_now = (ser_idx_reg == (char_count - 4'd1));
    end

    // Sequencer and output handshake
    assign out_load = !out_valid_reg || m_tready;
    assign ser_emit = ser_valid_reg && (char_count != '0) && out_load;
    assign ser_done = ser_valid_reg && ((char_count == '0) || (ser_emit && last_now));
    assign ser_free = !ser_valid_reg || ser_done;
    assign ser_take = ser_free && valid_reg[LAST];

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_idx_reg   <= '0;
        end
        else if (ser_take)
        begin
            ser_valid_reg <= 1'b1;
            ser_idx_reg   <= '0;
        end
        else if (ser_done)
        begin
            ser_valid_reg <= 1'b0;
        end
        else if (ser_emit)
        begin
            ser_idx_reg <= ser_idx_reg + 4'd1;
        end
    end

    // Sequencer digits
    always_ff @(posedge clk)
    begin
        if (ser_take)
        begin
            ser_bcd_reg <= bcd_reg[LAST];
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ser_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (ser_emit)
        begin
            out_char_reg <= char_now;
            out_last_reg <= last_now;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-width decimal formatter testbench
// Sends unsigned 32-bit numbers to the formatter and checks every character
// and end-of-run flag against typed text or a behavioural predictor of the
// decimal text. A directed table covers the field and register extremes, the
// saturated digit count, empty and dot-only runs, a point ahead of the shown
// digits and out-of-range point positions. Random numbers follow under
// several register settings, with random gaps and stalls on both streams and
// one long receiver hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_DIGITS     = fwdf_pkg::MAX_DIGITS_DEFAULT;
    localparam int FORMAT_LATENCY = 9;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SEGMENTS       = 12;
    localparam int SEGMENT_ITEMS  = 13;

    // One character of formatted output together with its end-of-run flag
    typedef struct packed {
        logic [fwdf_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } char_out_t;

    // One row of the directed table
    typedef struct packed {
        logic [fwdf_pkg::CFG_W-1:0]    digits;
        logic [fwdf_pkg::CFG_W-1:0]    dot;
        logic [fwdf_pkg::NUMBER_W-1:0] number;
    } text_row_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [fwdf_pkg::NUMBER_W-1:0] s_tdata   = '0;  // [31:0] number
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [fwdf_pkg::CHAR_W-1:0]   m_tdata;         // [7:0] character
    logic                          m_tlast;
    logic                          cfg_wr_en = 1'b0;
    logic                          cfg_index = fwdf_pkg::REG_DIGIT_COUNT;
    logic [fwdf_pkg::CFG_W-1:0]    cfg_wdata = '0;

    // Register copies used by the predictor
    logic [fwdf_pkg::CFG_W-1:0] digit_count  = fwdf_pkg::DIGIT_COUNT_RESET;
    logic [fwdf_pkg::CFG_W-1:0] dot_position = fwdf_pkg::DOT_POSITION_RESET;

    char_out_t awaited_chars[$];
    text_row_t text_rows[$];
    string     text_typed[$];

    int error_count    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_requested = 0;
    int hold_granted   = 0;
    int hold_left      = 0;

    fixed_width_decimal_formatter_unit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Decimal text of a number under the current digit count and point position.
    function automatic string decimal_text(input logic [fwdf_pkg::NUMBER_W-1:0] number);
        logic [3:0]                    digit [1:MAX_DIGITS];
        logic [fwdf_pkg::NUMBER_W-1:0] rest;
        int                            shown;
        logic                          dot_on;
        string                         text;
        rest   = number;
        text   = "";
        shown  = (int'(digit_count) > MAX_DIGITS) ? MAX_DIGITS : int'(digit_count);
        dot_on = (dot_position >= 4'd1) && (dot_position <= fwdf_pkg::DOT_LIMIT);
        for (int p = 1; p <= MAX_DIGITS; p++)
        begin
            digit[p] = 4'(rest % 10);
            rest     = rest / 10;
        end
        for (int p = MAX_DIGITS; p >= 1; p--)
        begin
            if (dot_on && int'(dot_position) == p)
            begin
                text = {text, "."};
            end
            if (p <= shown)
            begin
                text = $sformatf("%s%0d", text, digit[p]);
            end
        end
        return text;
    endfunction

    // Queue the characters of one run, flagging the final one.
    function automatic void await_text(input string text);
        char_out_t c;
        for (int i = 0; i < text.len(); i++)
        begin
            c.ch   = text[i];
            c.last = (i == text.len() - 1);
            awaited_chars.push_back(c);
        end
    endfunction

    // Random numbers weighted towards digit boundaries and the extremes.
    function automatic logic [fwdf_pkg::NUMBER_W-1:0] random_number();
        logic [fwdf_pkg::NUMBER_W-1:0] p;
        int                            k;
        p = 1;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 999);
            2:
            begin
                k = $urandom_range(0, 9);
                for (int i = 0; i < k; i++)
                begin
                    p = p * 10;
                end
                return p + $urandom_range(0, 2) - 1;
            end
            default: return 32'hFFFF_FFFF - $urandom_range(0, 20);
        endcase
    endfunction

    task automatic add_row(input int digits, input int dot,
                           input logic [fwdf_pkg::NUMBER_W-1:0] number,
                           input string typed);
        text_row_t r;
        r.digits = fwdf_pkg::CFG_W'(digits);
        r.dot    = fwdf_pkg::CFG_W'(dot);
        r.number = number;
        text_rows.push_back(r);
        text_typed.push_back(typed);
    endtask

    // Offer one number after a random gap; the request stays raised on return.
    // A typed text of "?" means the predictor supplies the expected run.
    task automatic send_number(input logic [fwdf_pkg::NUMBER_W-1:0] number,
                               input string typed);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= number;
        do
        begin
            @(posedge clk);
        end
        while (!(s_tvalid && s_tready));
        await_text((typed == "?") ? decimal_text(number) : typed);
    endtask

    // Drain the block, let any run without output clear, then load both registers.
    task automatic write_format(input logic [fwdf_pkg::CFG_W-1:0] digits,
                                input logic [fwdf_pkg::CFG_W-1:0] dot);
        s_tvalid <= 1'b0;
        while (awaited_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (FORMAT_LATENCY + 3) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= fwdf_pkg::REG_DIGIT_COUNT;
        cfg_wdata <= digits;
        @(posedge clk);
        cfg_index <= fwdf_pkg::REG_DOT_POSITION;
        cfg_wdata <= dot;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        digit_count  = digits;
        dot_position = dot;
    endtask

    // Output side: check each accepted character, then choose the next ready.
    always @(posedge clk)
    begin
        char_out_t want;
        if (m_tvalid && m_tready)
        begin
            if (awaited_chars.size() == 0)
            begin
                $error("unexpected character %0d (last %0d)", m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                want = awaited_chars.pop_front();
                if (m_tdata !== want.ch)
                begin
                    $error("character: expected %0d, got %0d", want.ch, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    error_count++;
                end
            end
        end
        if (hold_granted != hold_requested)
        begin
            hold_granted = hold_requested;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus.
    initial
    begin
        text_row_t                  row;
        logic [fwdf_pkg::CFG_W-1:0] digits;
        logic [fwdf_pkg::CFG_W-1:0] dot;

        // Directed table: register settings, number, expected text or "?".
        add_row( 3,  2, 32'd0,          "0.00");
        add_row( 3,  2, 32'd12345,      "3.45");
        add_row( 3,  2, 32'hFFFF_FFFF,  "2.95");
        add_row(12,  0, 32'hFFFF_FFFF,  "004294967295");
        add_row(12,  0, 32'd0,          "000000000000");
        add_row(12, 10, 32'hFFFF_FFFF,  "00.4294967295");
        add_row(12, 10, 32'd1234567890, "?");
        add_row(10, 10, 32'hFFFF_FFFF,  ".4294967295");
        add_row( 1,  0, 32'd7,          "7");
        add_row( 1,  1, 32'd9,          ".9");
        add_row( 0,  0, 32'd123,        "");
        add_row( 0,  3, 32'd123,        ".");
        add_row( 2,  5, 32'd98765,      ".65");
        add_row(15,  0, 32'hFFFF_FFFF,  "004294967295");
        add_row(13, 11, 32'd1,          "000000000001");
        add_row( 4, 15, 32'h8000_0000,  "3648");
        add_row( 5,  3, 32'hAAAA_AAAA,  "?");
        add_row( 5,  3, 32'h5555_5555,  "?");
        add_row( 5,  3, 32'd99999,      "99.999");
        add_row( 6,  6, 32'd100000,     ".100000");
        add_row(11,  9, 32'd4000000000, "04.000000000");
        add_row( 3,  2, 32'd1000,       "?");

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the sender mostly busy and the receiver mostly idle.
        send_idle_pct = 9;
        recv_idle_pct = 84;
        for (int i = 0; i < text_rows.size(); i++)
        begin
            row = text_rows[i];
            if (row.digits != digit_count || row.dot != dot_position)
            begin
                write_format(row.digits, row.dot);
            end
            send_number(row.number, text_typed[i]);
        end

        // Random part over several register settings, extremes first.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:       begin digits = 4'd12; dot = 4'd10; end
                1:       begin digits = 4'd1;  dot = 4'd1;  end
                2:       begin digits = 4'd15; dot = 4'd15; end
                3:       begin digits = 4'd4;  dot = 4'd0;  end
                default:
                begin
                    digits = ($urandom_range(0, 4) == 0)
                             ? fwdf_pkg::CFG_W'($urandom_range(0, 15))
                             : fwdf_pkg::CFG_W'($urandom_range(1, 12));
                    dot    = ($urandom_range(0, 4) == 0)
                             ? fwdf_pkg::CFG_W'($urandom_range(0, 15))
                             : fwdf_pkg::CFG_W'($urandom_range(0, 10));
                end
            endcase
            write_format(digits, dot);
            if (seg == 4)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 9;
            end
            else if (seg == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // The receiver holds off while numbers keep arriving back to back.
                hold_requested++;
            end
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                send_number(random_number(), "?");
            end
        end

        // Wait for every outstanding character, then let the pipeline settle.
        s_tvalid <= 1'b0;
        while (awaited_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * FORMAT_LATENCY) @(posedge clk);

        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/fwdf_pkg.sv
rtl/fixed_width_decimal_formatter_unit.sv
verif/testbench.sv
